// File: rtl/ipv4hp_pkg.sv
// ----------------------------------------------------------------------------
// ipv4hp_pkg
// Shared types, constants and helpers of the IPv4 header parser.
// ----------------------------------------------------------------------------
package ipv4hp_pkg;

  localparam int unsigned FixedBytes = 20;
  localparam int unsigned PosCap     = 64;

  localparam logic [6:0] OptStartPos = 7'd20;
  localparam logic [6:0] PosCapVal   = 7'd64;
  localparam logic [7:0] OptClsMask  = 8'h60;
  localparam logic [7:0] OptNumMask  = 8'h1F;
  localparam logic [7:0] IhlMask     = 8'h0F;
  localparam logic [3:0] IpVersion4  = 4'd4;

  localparam logic [7:0] ProtoIcmp = 8'd1;
  localparam logic [7:0] ProtoIgmp = 8'd2;
  localparam logic [7:0] ProtoTcp  = 8'd6;
  localparam logic [7:0] ProtoUdp  = 8'd17;

  typedef enum logic [1:0] {
    KIND_OPTION  = 2'd0,
    KIND_HEADER  = 2'd1,
    KIND_ADDRESS = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_IHL_SHORT = 2'd1,
    ST_BAD_VER   = 2'd2,
    ST_TRUNC     = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    PC_ICMP  = 3'd0,
    PC_IGMP  = 3'd1,
    PC_TCP   = 3'd2,
    PC_UDP   = 3'd3,
    PC_OTHER = 3'd4
  } proto_class_e;

  // Fixed header store, byte 0 is the first byte on the wire.
  typedef logic [FixedBytes-1:0][7:0] hdr_bytes_t;

  // Records produced by one accepted byte.
  typedef struct packed {
    logic       opt;      // one option record
    logic       hdr;      // header record followed by address record
    logic [1:0] cls;
    logic [4:0] num;
    logic [7:0] len;
    logic [5:0] idx;
    status_e    status;
  } rec_ev_t;

  function automatic proto_class_e proto_class(input logic [7:0] id);
    proto_class_e pc;
    case (id)
      ProtoIcmp: pc = PC_ICMP;
      ProtoIgmp: pc = PC_IGMP;
      ProtoTcp:  pc = PC_TCP;
      ProtoUdp:  pc = PC_UDP;
      default:   pc = PC_OTHER;
    endcase
    return pc;
  endfunction

endpackage

// File: rtl/ipv4hp_walker.sv
// ----------------------------------------------------------------------------
// ipv4hp_walker
// Byte position tracking, fixed header store and option walk.
// ----------------------------------------------------------------------------
module ipv4hp_walker (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  accept_i,
  input  logic [7:0]            packet_byte_i,
  input  logic                  end_of_packet_i,
  output ipv4hp_pkg::hdr_bytes_t store_o,
  output ipv4hp_pkg::rec_ev_t    ev_o
);

  logic [6:0] pos_q, pos_d;
  logic [6:0] nxt_q, nxt_d;
  logic       await_q, await_d;
  logic [1:0] pcls_q, pcls_d;
  logic [4:0] pnum_q, pnum_d;
  logic [5:0] cnt_q, cnt_d;
  logic       wdone_q, wdone_d;
  logic       rep_q, rep_d;
  ipv4hp_pkg::hdr_bytes_t store_q, store_d;

  logic       clr;
  logic [7:0] b0;
  logic [5:0] hl;
  logic [3:0] ver;
  logic       walk_en;
  logic       complete;
  logic       fire;
  logic [8:0] len_sum;
  logic [1:0] tcls;
  logic [4:0] tnum;
  logic [7:0] pos_p1;

  assign clr     = (pos_q == '0);
  assign b0      = clr ? packet_byte_i : store_q[0];
  assign hl      = {b0[3:0], 2'b00};
  assign ver     = b0[7:4];
  assign tcls    = 2'((packet_byte_i & ipv4hp_pkg::OptClsMask) >> 5);
  assign tnum    = 5'(packet_byte_i & ipv4hp_pkg::OptNumMask);
  assign len_sum = {2'b00, pos_q} + 9'd1 + {1'b0, packet_byte_i};
  assign pos_p1  = {1'b0, pos_q} + 8'd1;

  always_comb begin
    // packet start resets walk state before this byte is looked at
    store_d = clr ? '0 : store_q;
    nxt_d   = clr ? ipv4hp_pkg::OptStartPos : nxt_q;
    await_d = clr ? 1'b0 : await_q;
    pcls_d  = clr ? 2'd0 : pcls_q;
    pnum_d  = clr ? 5'd0 : pnum_q;
    cnt_d   = clr ? 6'd0 : cnt_q;
    wdone_d = clr ? 1'b0 : wdone_q;
    rep_d   = clr ? 1'b0 : rep_q;

    if (pos_q < 7'(ipv4hp_pkg::FixedBytes)) begin
      store_d[pos_q[4:0]] = packet_byte_i;
    end

    ev_o        = '0;
    ev_o.status = ipv4hp_pkg::ST_OK;
    ev_o.idx    = cnt_d;

    walk_en = !rep_d && !wdone_d && (pos_q >= ipv4hp_pkg::OptStartPos) &&
              (pos_q < {1'b0, hl});
    if (walk_en) begin
      if (await_d) begin
        await_d    = 1'b0;
        ev_o.opt   = 1'b1;
        ev_o.cls   = pcls_d;
        ev_o.num   = pnum_d;
        ev_o.len   = packet_byte_i;
        nxt_d      = (len_sum > 9'(ipv4hp_pkg::PosCap)) ? ipv4hp_pkg::PosCapVal
                                                         : len_sum[6:0];
      end else if (pos_q == nxt_d) begin
        if (packet_byte_i == '0) begin
          wdone_d = 1'b1;
        end else if (tnum < 5'd2) begin
          ev_o.opt = 1'b1;
          ev_o.cls = tcls;
          ev_o.num = tnum;
          ev_o.len = '0;
          nxt_d    = pos_p1[6:0];
        end else begin
          await_d = 1'b1;
          pcls_d  = tcls;
          pnum_d  = tnum;
        end
      end
    end

    complete = (pos_q >= 7'd19) && (pos_p1 >= {2'b00, hl});
    fire     = !rep_d && (complete || end_of_packet_i);
    if (fire) begin
      ev_o.hdr = 1'b1;
      rep_d    = 1'b1;
      if (!complete) begin
        ev_o.status = ipv4hp_pkg::ST_TRUNC;
      end else if (ver != ipv4hp_pkg::IpVersion4) begin
        ev_o.status = ipv4hp_pkg::ST_BAD_VER;
      end else if (hl < 6'(ipv4hp_pkg::FixedBytes)) begin
        ev_o.status = ipv4hp_pkg::ST_IHL_SHORT;
      end
      // a type byte still waiting for its length goes out with length zero
      if (await_d) begin
        await_d  = 1'b0;
        ev_o.opt = 1'b1;
        ev_o.cls = pcls_d;
        ev_o.num = pnum_d;
        ev_o.len = '0;
      end
    end

    if (ev_o.opt) begin
      cnt_d = cnt_d + 6'd1;
    end

    if (end_of_packet_i) begin
      pos_d = '0;
    end else begin
      pos_d = (pos_p1 > 8'(ipv4hp_pkg::PosCap)) ? ipv4hp_pkg::PosCapVal : pos_p1[6:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      nxt_q   <= ipv4hp_pkg::OptStartPos;
      await_q <= 1'b0;
      pcls_q  <= '0;
      pnum_q  <= '0;
      cnt_q   <= '0;
      wdone_q <= 1'b0;
      rep_q   <= 1'b0;
      store_q <= '0;
    end else if (accept_i) begin
      pos_q   <= pos_d;
      nxt_q   <= nxt_d;
      await_q <= await_d;
      pcls_q  <= pcls_d;
      pnum_q  <= pnum_d;
      cnt_q   <= cnt_d;
      wdone_q <= wdone_d;
      rep_q   <= rep_d;
      store_q <= store_d;
    end
  end

  assign store_o = store_q;

endmodule

// File: rtl/ipv4hp_emitter.sv
// ----------------------------------------------------------------------------
// ipv4hp_emitter
// Result register: holds up to three records of one byte, sends them in order.
// ----------------------------------------------------------------------------
module ipv4hp_emitter (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   load_i,
  input  ipv4hp_pkg::rec_ev_t    ev_i,
  input  ipv4hp_pkg::hdr_bytes_t store_i,
  output logic                   in_ready_o,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [1:0]             kind_o,
  output logic                   last_o,
  output logic [1:0]             status_o,
  output logic [7:0]             small_a_o,
  output logic [7:0]             small_b_o,
  output logic [7:0]             small_c_o,
  output logic [2:0]             protocol_class_o,
  output logic [3:0]             version_o,
  output logic [5:0]             length_or_index_o,
  output logic [31:0]            word_a_o,
  output logic [31:0]            word_b_o
);

  logic               opt_q, opt_d;
  logic               hdr_q, hdr_d;
  logic               adr_q, adr_d;
  ipv4hp_pkg::rec_ev_t ev_q;
  logic               out_acc;
  logic [1:0]         pending;

  assign pending     = 2'(opt_q) + 2'(hdr_q) + 2'(adr_q);
  assign out_valid_o = opt_q | hdr_q | adr_q;
  assign out_acc     = out_valid_o & out_ready_i;
  // store stays frozen while header/address records wait
  assign in_ready_o  = (pending == 2'd0) || ((pending == 2'd1) && out_ready_i);

  always_comb begin
    opt_d = opt_q;
    hdr_d = hdr_q;
    adr_d = adr_q;
    if (out_acc) begin
      if (opt_q) begin
        opt_d = 1'b0;
      end else if (hdr_q) begin
        hdr_d = 1'b0;
      end else begin
        adr_d = 1'b0;
      end
    end
    if (load_i) begin
      opt_d = ev_i.opt;
      hdr_d = ev_i.hdr;
      adr_d = ev_i.hdr;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      opt_q <= 1'b0;
      hdr_q <= 1'b0;
      adr_q <= 1'b0;
    end else begin
      opt_q <= opt_d;
      hdr_q <= hdr_d;
      adr_q <= adr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      ev_q <= ev_i;
    end
  end

  always_comb begin
    kind_o            = ipv4hp_pkg::KIND_ADDRESS;
    last_o            = 1'b0;
    status_o          = ipv4hp_pkg::ST_OK;
    small_a_o         = '0;
    small_b_o         = '0;
    small_c_o         = '0;
    protocol_class_o  = '0;
    version_o         = '0;
    length_or_index_o = '0;
    word_a_o          = '0;
    word_b_o          = '0;
    if (opt_q) begin
      kind_o            = ipv4hp_pkg::KIND_OPTION;
      small_a_o         = {6'd0, ev_q.cls};
      small_b_o         = {3'd0, ev_q.num};
      small_c_o         = ev_q.len;
      length_or_index_o = ev_q.idx;
    end else if (hdr_q) begin
      kind_o            = ipv4hp_pkg::KIND_HEADER;
      status_o          = ev_q.status;
      small_a_o         = store_i[1];
      small_b_o         = store_i[8];
      small_c_o         = store_i[9];
      protocol_class_o  = ipv4hp_pkg::proto_class(store_i[9]);
      version_o         = store_i[0][7:4];
      length_or_index_o = {store_i[0][3:0], 2'b00};
      word_a_o          = {store_i[2], store_i[3], store_i[4], store_i[5]};
      word_b_o          = {store_i[6], store_i[7], store_i[10], store_i[11]};
    end else begin
      last_o   = 1'b1;
      word_a_o = {store_i[12], store_i[13], store_i[14], store_i[15]};
      word_b_o = {store_i[16], store_i[17], store_i[18], store_i[19]};
    end
  end

endmodule

// File: rtl/ipv4_header_parser.sv
// ----------------------------------------------------------------------------
// ipv4_header_parser
// Byte-wide IPv4 header parser: option, header and address records.
// ----------------------------------------------------------------------------
//  channel | handshake                 | payload
//  --------+---------------------------+--------------------------------------
//  in      | in_valid_i / in_ready_o   | packet_byte_i, end_of_packet_i
//  out     | out_valid_o / out_ready_i | kind, last, status, small_a/b/c,
//          |                           | protocol_class, version,
//          |                           | length_or_index, word_a, word_b
//
//  Each byte is handled in the cycle it is accepted; its records appear in
//  the next cycle from the result register.
//  A byte gives zero to three records, one record per output transaction;
//  payload bytes run at one per cycle while the result register is empty.
//  The result register holds up to three records.
//  While two or more records are waiting, in_ready_o is low, which also keeps
//  the header store steady for the header and address records.
//  Reset (rst_ni low, asynchronous) clears position, walk state and store;
//  the first byte after reset or after an end-of-packet byte starts a packet.
// ----------------------------------------------------------------------------
module ipv4_header_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  packet_byte_i,
  input  logic        end_of_packet_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  kind_o,
  output logic        last_o,
  output logic [1:0]  status_o,
  output logic [7:0]  small_a_o,
  output logic [7:0]  small_b_o,
  output logic [7:0]  small_c_o,
  output logic [2:0]  protocol_class_o,
  output logic [3:0]  version_o,
  output logic [5:0]  length_or_index_o,
  output logic [31:0] word_a_o,
  output logic [31:0] word_b_o
);

  logic                   in_acc;
  ipv4hp_pkg::rec_ev_t    ev;
  ipv4hp_pkg::hdr_bytes_t store;

  // a transaction on the input side updates walk state and loads results
  assign in_acc = in_valid_i & in_ready_o;

  ipv4hp_walker u_walker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .accept_i        (in_acc),
    .packet_byte_i   (packet_byte_i),
    .end_of_packet_i (end_of_packet_i),
    .store_o         (store),
    .ev_o            (ev)
  );

  // records leave in order: option, header, address
  ipv4hp_emitter u_emitter (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .load_i            (in_acc),
    .ev_i              (ev),
    .store_i           (store),
    .in_ready_o        (in_ready_o),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .kind_o            (kind_o),
    .last_o            (last_o),
    .status_o          (status_o),
    .small_a_o         (small_a_o),
    .small_b_o         (small_b_o),
    .small_c_o         (small_c_o),
    .protocol_class_o  (protocol_class_o),
    .version_o         (version_o),
    .length_or_index_o (length_or_index_o),
    .word_a_o          (word_a_o),
    .word_b_o          (word_b_o)
  );

endmodule

// File: rtl/ipv4hp_checker.sv
// ----------------------------------------------------------------------------
// ipv4hp_checker
// Port-level checks of the IPv4 header parser, bound to the top level.
// ----------------------------------------------------------------------------
module ipv4hp_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_ready_o,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [1:0] kind_o,
  input logic       last_o,
  input logic [1:0] status_o
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // the address record always follows its header record
  a_adr_after_hdr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && kind_o == ipv4hp_pkg::KIND_HEADER |=>
      out_valid_o && kind_o == ipv4hp_pkg::KIND_ADDRESS)
    else $error("address record missing after header");

  // last marks exactly the address record
  a_last_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (last_o == (kind_o == ipv4hp_pkg::KIND_ADDRESS)))
    else $error("last flag on wrong record");

  // option records carry no status
  a_opt_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == ipv4hp_pkg::KIND_OPTION |-> status_o == ipv4hp_pkg::ST_OK)
    else $error("status on option record");

  // while a header record is offered its address record waits too, so no new byte is taken
  a_hdr_blocks_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == ipv4hp_pkg::KIND_HEADER |-> !in_ready_o)
    else $error("input taken while header and address pending");

endmodule

bind ipv4_header_parser ipv4hp_checker u_ipv4hp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .kind_o      (kind_o),
  .last_o      (last_o),
  .status_o    (status_o)
);

// File: tb/tb_ipv4_header_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ipv4_header_parser
// Self-checking bench for the byte-wide IPv4 header parser.
// Packets are fed one byte per transaction. A built-in parser model predicts
// the option, header and address records, and a monitor checks every output
// transaction field by field, in order. Directed packets come first, then
// random packets. Both channels idle at random, apart from one stretch with
// no gaps at all.
// ----------------------------------------------------------------------------
module tb_ipv4_header_parser;

  // Expected record, one per output transaction.
  typedef struct packed {
    ipv4hp_pkg::kind_e        kind;
    logic                     last;
    ipv4hp_pkg::status_e      status;
    logic [7:0]               sa;
    logic [7:0]               sb;
    logic [7:0]               sc;
    ipv4hp_pkg::proto_class_e pclass;
    logic [3:0]               ver;
    logic [5:0]               li;
    logic [31:0]              wa;
    logic [31:0]              wb;
  } parse_rec_t;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [7:0]  packet_byte_i;
  logic        end_of_packet_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [1:0]  kind_o;
  logic        last_o;
  logic [1:0]  status_o;
  logic [7:0]  small_a_o;
  logic [7:0]  small_b_o;
  logic [7:0]  small_c_o;
  logic [2:0]  protocol_class_o;
  logic [3:0]  version_o;
  logic [5:0]  length_or_index_o;
  logic [31:0] word_a_o;
  logic [31:0] word_b_o;

  ipv4_header_parser DUT (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .packet_byte_i    (packet_byte_i),
    .end_of_packet_i  (end_of_packet_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .kind_o           (kind_o),
    .last_o           (last_o),
    .status_o         (status_o),
    .small_a_o        (small_a_o),
    .small_b_o        (small_b_o),
    .small_c_o        (small_c_o),
    .protocol_class_o (protocol_class_o),
    .version_o        (version_o),
    .length_or_index_o(length_or_index_o),
    .word_a_o         (word_a_o),
    .word_b_o         (word_b_o)
  );

  // 8 ns clock
  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  // --------------------------------------------------------------------------
  // Parser model state (mirrors the block's per-packet state)
  // --------------------------------------------------------------------------
  logic [7:0]  hdr_store [0:19];
  int unsigned wire_pos;        // byte position in packet, saturates at 64
  int unsigned next_opt_pos;    // where the next option type byte sits
  logic        await_len;       // type byte seen, length byte still to come
  logic [1:0]  pend_cls;
  logic [4:0]  pend_num;
  logic [5:0]  opt_idx;
  logic        walk_done;       // end-of-list option seen
  logic        hdr_sent;        // header/address pair already produced

  parse_rec_t  pending_records [$];
  logic [7:0]  pkt_bytes [$];   // packet under construction

  int unsigned error_count;
  int unsigned bytes_sent;
  int unsigned packets_sent;
  int unsigned records_checked;
  int unsigned option_records;
  int unsigned status_seen [4];

  bit          idle_en;         // random gaps on both channels
  int unsigned hold_cycles;     // receiver hold-off, counted down per cycle

  function automatic void clear_packet_state();
    for (int i = 0; i < 20; i++) hdr_store[i] = 8'h00;
    next_opt_pos = 20;
    await_len    = 1'b0;
    pend_cls     = '0;
    pend_num     = '0;
    opt_idx      = '0;
    walk_done    = 1'b0;
    hdr_sent     = 1'b0;
  endfunction

  function automatic void push_option(logic [1:0] cls, logic [4:0] num, logic [7:0] len);
    parse_rec_t r;
    r        = '0;
    r.kind   = ipv4hp_pkg::KIND_OPTION;
    r.status = ipv4hp_pkg::ST_OK;
    r.sa     = {6'd0, cls};
    r.sb     = {3'd0, num};
    r.sc     = len;
    r.li     = opt_idx;
    opt_idx  = opt_idx + 6'd1;
    option_records++;
    pending_records.push_back(r);
  endfunction

  function automatic logic [31:0] store_word(int unsigned p);
    return {hdr_store[p], hdr_store[p+1], hdr_store[p+2], hdr_store[p+3]};
  endfunction

  function automatic ipv4hp_pkg::proto_class_e class_of_proto(logic [7:0] id);
    case (id)
      ipv4hp_pkg::ProtoIcmp: return ipv4hp_pkg::PC_ICMP;
      ipv4hp_pkg::ProtoIgmp: return ipv4hp_pkg::PC_IGMP;
      ipv4hp_pkg::ProtoTcp:  return ipv4hp_pkg::PC_TCP;
      ipv4hp_pkg::ProtoUdp:  return ipv4hp_pkg::PC_UDP;
      default:               return ipv4hp_pkg::PC_OTHER;
    endcase
  endfunction

  // Advance the model by one accepted byte and queue the records it yields.
  function automatic void parse_byte(logic [7:0] value, logic eop);
    int unsigned         p;
    int unsigned         hl;
    int unsigned         nx;
    logic                complete;
    logic [3:0]          ver;
    ipv4hp_pkg::status_e st;
    parse_rec_t          r;
    p = wire_pos;
    if (p == 0) clear_packet_state();
    if (p < 20) hdr_store[p] = value;
    hl = 32'(hdr_store[0][3:0]) * 4;

    // option walk over bytes 20 .. IHL*4-1
    if (!hdr_sent && !walk_done && p >= 20 && p < hl) begin
      if (await_len) begin
        await_len = 1'b0;
        push_option(pend_cls, pend_num, value);
        nx = p + 1 + 32'(value);
        next_opt_pos = (nx > 64) ? 64 : nx;
      end else if (p == next_opt_pos) begin
        if (value == 8'h00) begin
          walk_done = 1'b1;
        end else if (value[4:0] < 5'd2) begin
          push_option(value[6:5], value[4:0], 8'h00);
          next_opt_pos = p + 1;
        end else begin
          await_len = 1'b1;
          pend_cls  = value[6:5];
          pend_num  = value[4:0];
        end
      end
    end

    if (!hdr_sent) begin
      complete = (p >= 19) && (p + 1 >= hl);
      if (complete || eop) begin
        ver = hdr_store[0][7:4];
        if (!complete)                         st = ipv4hp_pkg::ST_TRUNC;
        else if (ver != ipv4hp_pkg::IpVersion4) st = ipv4hp_pkg::ST_BAD_VER;
        else if (hl < 20)                      st = ipv4hp_pkg::ST_IHL_SHORT;
        else                                   st = ipv4hp_pkg::ST_OK;
        // option type byte whose length never arrived
        if (await_len) begin
          await_len = 1'b0;
          push_option(pend_cls, pend_num, 8'h00);
        end
        r        = '0;
        r.kind   = ipv4hp_pkg::KIND_HEADER;
        r.status = st;
        r.sa     = hdr_store[1];
        r.sb     = hdr_store[8];
        r.sc     = hdr_store[9];
        r.pclass = class_of_proto(hdr_store[9]);
        r.ver    = ver;
        r.li     = hl[5:0];
        r.wa     = store_word(2);
        r.wb     = {hdr_store[6], hdr_store[7], hdr_store[10], hdr_store[11]};
        pending_records.push_back(r);
        r        = '0;
        r.kind   = ipv4hp_pkg::KIND_ADDRESS;
        r.status = ipv4hp_pkg::ST_OK;
        r.last   = 1'b1;
        r.wa     = store_word(12);
        r.wb     = store_word(16);
        pending_records.push_back(r);
        status_seen[st]++;
        hdr_sent = 1'b1;
      end
    end

    if (eop) wire_pos = 0;
    else     wire_pos = (p + 1 > 64) ? 64 : p + 1;
  endfunction

  // --------------------------------------------------------------------------
  // Checking: every output transaction against the oldest expected record
  // --------------------------------------------------------------------------
  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t ns: mismatch on %s: expected 0x%0h, actual 0x%0h",
               $time, name, want, got);
      error_count++;
    end
  endfunction

  always @(posedge clk_i) begin
    parse_rec_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_records.size() == 0) begin
        $display("%0t ns: unexpected record, kind %0d, nothing expected", $time, kind_o);
        error_count++;
      end else begin
        want = pending_records.pop_front();
        check_field("kind",            32'(want.kind),   32'(kind_o));
        check_field("last",            32'(want.last),   32'(last_o));
        check_field("status",          32'(want.status), 32'(status_o));
        check_field("small_a",         32'(want.sa),     32'(small_a_o));
        check_field("small_b",         32'(want.sb),     32'(small_b_o));
        check_field("small_c",         32'(want.sc),     32'(small_c_o));
        check_field("protocol_class",  32'(want.pclass), 32'(protocol_class_o));
        check_field("version",         32'(want.ver),    32'(version_o));
        check_field("length_or_index", 32'(want.li),     32'(length_or_index_o));
        check_field("word_a",          want.wa,          word_a_o);
        check_field("word_b",          want.wb,          word_b_o);
        records_checked++;
      end
    end
  end

  // Receiver: random stalls, or a counted hold-off when a test asks for one.
  initial begin
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_cycles > 0) begin
        out_ready_i <= 1'b0;
        hold_cycles--;
      end else if (!idle_en) begin
        out_ready_i <= 1'b1;
      end else begin
        out_ready_i <= ($urandom_range(0, 99) >= 36);
      end
    end
  end

  // Run limit, far above the slowest legal run.
  initial begin
    #3ms;
    $display("Timeout: %0d records still expected", pending_records.size());
    $display("TEST FAILED");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Sending. Called at a falling edge, returns at a falling edge. Valid is
  // left high after a transaction so back-to-back bytes need one assignment.
  // --------------------------------------------------------------------------
  task automatic send_byte(input logic [7:0] value, input logic eop);
    if (idle_en && $urandom_range(0, 99) < 36) begin
      in_valid_i <= 1'b0;
      do @(negedge clk_i); while ($urandom_range(0, 99) < 36);
    end
    in_valid_i      <= 1'b1;
    packet_byte_i   <= value;
    end_of_packet_i <= eop;
    do @(posedge clk_i); while (!in_ready_o);
    parse_byte(value, eop);
    bytes_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_packet();
    for (int i = 0; i < pkt_bytes.size(); i++)
      send_byte(pkt_bytes[i], i == pkt_bytes.size() - 1);
    packets_sent++;
  endtask

  // 20-byte fixed header with random TOS/ids/TTL/addresses.
  task automatic build_header(input logic [7:0] ver_ihl, input logic [7:0] proto);
    pkt_bytes.delete();
    pkt_bytes.push_back(ver_ihl);
    for (int i = 1; i < 20; i++)
      pkt_bytes.push_back(i == 9 ? proto : 8'($urandom));
  endtask

  task automatic add_random_bytes(input int unsigned n);
    repeat (n) pkt_bytes.push_back(8'($urandom));
  endtask

  task automatic add_bytes(input logic [63:0] data, input int unsigned n);
    for (int i = n - 1; i >= 0; i--) pkt_bytes.push_back(data[8*i +: 8]);
  endtask

  // Well-formed option list filling 'room' bytes, with the odd broken length.
  task automatic add_random_options(input int unsigned room);
    int unsigned left;
    int unsigned len;
    int unsigned pick;
    left = room;
    while (left > 0) begin
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
        // end of option list, rest is padding
        pkt_bytes.push_back(8'h00);
        add_random_bytes(left - 1);
        left = 0;
      end else if (pick < 4 || left == 1) begin
        pkt_bytes.push_back({3'($urandom), 5'($urandom_range(0, 1))});
        left--;
      end else begin
        pkt_bytes.push_back({3'($urandom), 5'($urandom_range(2, 31))});
        if (pick == 9) begin
          // length that disagrees with the room left
          pkt_bytes.push_back(8'($urandom));
          add_random_bytes(left - 2);
          left = 0;
        end else begin
          len = $urandom_range(2, left);
          pkt_bytes.push_back(8'(len));
          add_random_bytes(len - 2);
          left -= len;
        end
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Plain header with a short IHL and a payload byte, and a one-byte packet.
  task automatic test_fixed_header();
    build_header(8'h43, ipv4hp_pkg::ProtoUdp);
    add_random_bytes(1);
    send_packet();
    // single-byte packet ends before the header
    pkt_bytes = '{8'h45};
    send_packet();
  endtask

  // Option walk: one-byte numbers, a length that skips bytes, and a type byte
  // cut off by the header end.
  task automatic test_option_walk();
    // IHL 7: 0x21 | DF 03 AA | 7E 02 | 60 | 44 (cut off at the last byte)
    build_header(8'h47, ipv4hp_pkg::ProtoTcp);
    add_bytes(64'h21DF03AA7E026044, 8);
    send_packet();
  endtask

  // Status codes and their priority.
  task automatic test_header_status();
    build_header(8'h65, ipv4hp_pkg::ProtoTcp);
    pkt_bytes = pkt_bytes[0:4];       // truncation wins over bad version
    send_packet();
    build_header(8'h33, ipv4hp_pkg::ProtoIcmp);   // bad version wins over short IHL
    send_packet();
  endtask

  // Receiver holds off while a packet with one-byte options streams in, so
  // the result register fills and the input stalls. The options end in a
  // length that pushes the next option position past the cap, and the
  // payload runs past the byte position cap. No idling on either side.
  task automatic test_backpressure();
    idle_en     = 1'b0;
    hold_cycles = 100;
    build_header(8'h48, ipv4hp_pkg::ProtoIgmp);
    add_bytes(64'h01010101010188FF, 8);
    add_random_bytes(38);
    send_packet();
    idle_en = 1'b1;
  endtask

  // Random packets: mostly well-formed with random content, some truncated,
  // some pure noise.
  task automatic test_random_packets();
    int unsigned mode;
    logic [3:0]  ihl;
    logic [7:0]  protos [5];
    protos = '{ipv4hp_pkg::ProtoIcmp, ipv4hp_pkg::ProtoIgmp, ipv4hp_pkg::ProtoTcp,
               ipv4hp_pkg::ProtoUdp, 8'd0};
    while (bytes_sent < 150) begin
      mode = $urandom_range(0, 99);
      ihl  = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(5, 15))
                                         : 4'($urandom_range(5, 6));
      if (mode < 70) begin
        build_header({ipv4hp_pkg::IpVersion4, ihl}, protos[$urandom_range(0, 3)] |
                     ($urandom_range(0, 4) == 0 ? 8'($urandom) : 8'h00));
        add_random_options(32'(ihl) * 4 - 20);
        add_random_bytes($urandom_range(0, 2));
      end else if (mode < 85) begin
        // keep the header, cut the packet short
        build_header({ipv4hp_pkg::IpVersion4, ihl}, protos[$urandom_range(0, 4)]);
        add_random_options(32'(ihl) * 4 - 20);
        pkt_bytes = pkt_bytes[0:$urandom_range(0, 32'(ihl) * 4 - 2)];
      end else begin
        pkt_bytes.delete();
        add_random_bytes($urandom_range(1, 30));
      end
      send_packet();
    end
  endtask

  task automatic finish_run();
    in_valid_i <= 1'b0;
    while (pending_records.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    $display("Covered %0d packets, %0d bytes, %0d records checked (%0d options)",
             packets_sent, bytes_sent, records_checked, option_records);
    $display("Header status ok/short IHL/bad version/truncated: %0d/%0d/%0d/%0d",
             status_seen[ipv4hp_pkg::ST_OK], status_seen[ipv4hp_pkg::ST_IHL_SHORT],
             status_seen[ipv4hp_pkg::ST_BAD_VER], status_seen[ipv4hp_pkg::ST_TRUNC]);
    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  endtask

  initial begin
    in_valid_i      = 1'b0;
    packet_byte_i   = 8'h00;
    end_of_packet_i = 1'b0;
    rst_ni          = 1'b0;
    idle_en         = 1'b1;
    hold_cycles     = 0;
    error_count     = 0;
    bytes_sent      = 0;
    packets_sent    = 0;
    records_checked = 0;
    option_records  = 0;
    status_seen     = '{0, 0, 0, 0};
    wire_pos        = 0;
    clear_packet_state();
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_fixed_header();
    test_option_walk();
    test_header_status();
    test_backpressure();
    test_random_packets();
    finish_run();
  end

endmodule
